>>> src/sit_pkg.sv
// Package for the segment intersection tests: query kinds, orientation codes
// and the helpers that turn sign tests into orientation codes.
// No dependencies.
package sit_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int KIND_BITS = 3;
  localparam int TURN_BITS = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LINE_LINE    = 3'd0,
    KIND_LINE_SEGMENT = 3'd1,
    KIND_LINE_POINT   = 3'd2,
    KIND_SEG_SEG      = 3'd3,
    KIND_ORIENT       = 3'd4
  } kind_t;

  typedef logic signed [TURN_BITS-1:0] turn_t;

  localparam turn_t TURN_CCW     = 3'sd1;
  localparam turn_t TURN_CW      = -3'sd1;
  localparam turn_t TURN_BEHIND  = 3'sd2;
  localparam turn_t TURN_BEYOND  = -3'sd2;
  localparam turn_t TURN_BETWEEN = 3'sd0;

  // Orientation of c against a->b from the sign of the cross product, the sign
  // of the dot product and whether |c-a| exceeds |b-a|.
  function automatic turn_t orient_code(input logic cross_pos, input logic cross_neg,
                                        input logic dot_neg, input logic far);
    turn_t code;
    if (cross_pos) begin
      code = TURN_CCW;
    end else if (cross_neg) begin
      code = TURN_CW;
    end else if (dot_neg) begin
      code = TURN_BEHIND;
    end else if (far) begin
      code = TURN_BEYOND;
    end else begin
      code = TURN_BETWEEN;
    end
    return code;
  endfunction

  // True when the product of two orientation codes is zero or negative.
  function automatic logic straddles(input turn_t a, input turn_t b);
    return (a == TURN_BETWEEN) || (b == TURN_BETWEEN) || (a[TURN_BITS-1] != b[TURN_BITS-1]);
  endfunction

endpackage

>>> src/sit_if.sv
// Handshake channels of the segment intersection tests: query in, result out.
// Depends on sit_pkg.
interface sit_query_if #(parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT);
  import sit_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [KIND_BITS-1:0]        kind;
  logic signed [COORD_BITS-1:0] p0_x;
  logic signed [COORD_BITS-1:0] p0_y;
  logic signed [COORD_BITS-1:0] p1_x;
  logic signed [COORD_BITS-1:0] p1_y;
  logic signed [COORD_BITS-1:0] p2_x;
  logic signed [COORD_BITS-1:0] p2_y;
  logic signed [COORD_BITS-1:0] p3_x;
  logic signed [COORD_BITS-1:0] p3_y;

  modport source (output valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  input ready);
  modport sink (input valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                output ready);
endinterface

interface sit_result_if;
  import sit_pkg::*;
  logic  valid;
  logic  ready;
  logic  hit;
  turn_t turn;

  modport source (output valid, hit, turn, input ready);
  modport sink (input valid, hit, turn, output ready);
endinterface

>>> src/segment_intersection_tests.sv
// Segment intersection tests: orientation and line/segment/point intersection
// on four points with exact integer arithmetic. Depends on sit_pkg, sit_if.
//
//   channel  dir  payload
//   query    in   kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
//   result   out  hit, turn
//
// One item per cycle when the result side is not stalled; three register
// stages (differences, products and sums, result), which a query passes in order.
// Synchronous reset empties all stages. Each stage moves on when the next one is
// empty or moving, so a stalled result holds and the stages behind it fill up.
module segment_intersection_tests #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  sit_query_if.sink query,
  sit_result_if.source result
);
  import sit_pkg::*;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int CROSS_W = 2 * COORD_BITS + 2;
  localparam int SQ_W    = 2 * COORD_BITS + 1;

  logic valid_a, valid_b, valid_c;
  logic load_a, load_b, load_c;

  logic [KIND_BITS-1:0] kind_a, kind_b;
  logic signed [DIFF_W-1:0] dx, dy, ex, ey, fx, fy, gx, gy, hx, hy;

  logic signed [CROSS_W-1:0] cr_de, cr_df, cr_dg, cr_ef, cr_eh;
  logic signed [CROSS_W-1:0] dt_df, dt_dg, dt_ef, dt_eh;
  logic [SQ_W-1:0] sq_d, sq_e, sq_f, sq_g, sq_h;

  logic  hit, hit_next;
  turn_t turn, turn_next;
  turn_t o_012, o_013, o_230, o_231;

  assign load_c = !valid_c || result.ready;
  assign load_b = !valid_b || load_c;
  assign load_a = !valid_a || load_b;
  assign query.ready = load_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      if (load_a) valid_a <= query.valid;
      if (load_b) valid_b <= valid_a;
      if (load_c) valid_c <= valid_b;
    end
  end

  // difference stage
  always_ff @(posedge clk) begin
    if (load_a) begin
      kind_a <= query.kind;
      dx <= DIFF_W'(query.p1_x) - DIFF_W'(query.p0_x);
      dy <= DIFF_W'(query.p1_y) - DIFF_W'(query.p0_y);
      ex <= DIFF_W'(query.p3_x) - DIFF_W'(query.p2_x);
      ey <= DIFF_W'(query.p3_y) - DIFF_W'(query.p2_y);
      fx <= DIFF_W'(query.p2_x) - DIFF_W'(query.p0_x);
      fy <= DIFF_W'(query.p2_y) - DIFF_W'(query.p0_y);
      gx <= DIFF_W'(query.p3_x) - DIFF_W'(query.p0_x);
      gy <= DIFF_W'(query.p3_y) - DIFF_W'(query.p0_y);
      hx <= DIFF_W'(query.p1_x) - DIFF_W'(query.p2_x);
      hy <= DIFF_W'(query.p1_y) - DIFF_W'(query.p2_y);
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (load_b) begin
      kind_b <= kind_a;
      cr_de <= CROSS_W'(dx) * CROSS_W'(ey) - CROSS_W'(dy) * CROSS_W'(ex);
      cr_df <= CROSS_W'(dx) * CROSS_W'(fy) - CROSS_W'(dy) * CROSS_W'(fx);
      cr_dg <= CROSS_W'(dx) * CROSS_W'(gy) - CROSS_W'(dy) * CROSS_W'(gx);
      cr_ef <= CROSS_W'(ex) * CROSS_W'(fy) - CROSS_W'(ey) * CROSS_W'(fx);
      cr_eh <= CROSS_W'(ex) * CROSS_W'(hy) - CROSS_W'(ey) * CROSS_W'(hx);
      dt_df <= CROSS_W'(dx) * CROSS_W'(fx) + CROSS_W'(dy) * CROSS_W'(fy);
      dt_dg <= CROSS_W'(dx) * CROSS_W'(gx) + CROSS_W'(dy) * CROSS_W'(gy);
      dt_ef <= CROSS_W'(ex) * CROSS_W'(fx) + CROSS_W'(ey) * CROSS_W'(fy);
      dt_eh <= CROSS_W'(ex) * CROSS_W'(hx) + CROSS_W'(ey) * CROSS_W'(hy);
      sq_d  <= SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
      sq_e  <= SQ_W'(ex) * SQ_W'(ex) + SQ_W'(ey) * SQ_W'(ey);
      sq_f  <= SQ_W'(fx) * SQ_W'(fx) + SQ_W'(fy) * SQ_W'(fy);
      sq_g  <= SQ_W'(gx) * SQ_W'(gx) + SQ_W'(gy) * SQ_W'(gy);
      sq_h  <= SQ_W'(hx) * SQ_W'(hx) + SQ_W'(hy) * SQ_W'(hy);
    end
  end

  // orientations: p2 and p3 against p0->p1, p0 and p1 against p2->p3
  always_comb begin
    o_012 = orient_code(!cr_df[CROSS_W-1] && (cr_df != '0), cr_df[CROSS_W-1],
                        dt_df[CROSS_W-1], sq_d < sq_f);
    o_013 = orient_code(!cr_dg[CROSS_W-1] && (cr_dg != '0), cr_dg[CROSS_W-1],
                        dt_dg[CROSS_W-1], sq_d < sq_g);
    o_230 = orient_code(cr_ef[CROSS_W-1], !cr_ef[CROSS_W-1] && (cr_ef != '0),
                        !dt_ef[CROSS_W-1] && (dt_ef != '0), sq_e < sq_f);
    o_231 = orient_code(!cr_eh[CROSS_W-1] && (cr_eh != '0), cr_eh[CROSS_W-1],
                        dt_eh[CROSS_W-1], sq_e < sq_h);
  end

  always_comb begin
    hit_next  = 1'b0;
    turn_next = TURN_BETWEEN;
    case (kind_b)
      KIND_LINE_LINE: begin
        hit_next = (cr_de != '0) || (cr_df == '0);
      end
      KIND_LINE_SEGMENT: begin
        hit_next = (cr_df == '0) || (cr_dg == '0) ||
                   (cr_df[CROSS_W-1] != cr_dg[CROSS_W-1]);
      end
      KIND_LINE_POINT: begin
        hit_next = (cr_df == '0);
      end
      KIND_SEG_SEG: begin
        hit_next = straddles(o_012, o_013) && straddles(o_230, o_231);
      end
      KIND_ORIENT: begin
        turn_next = o_012;
      end
      default: begin
        hit_next  = 1'b0;
        turn_next = TURN_BETWEEN;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_c) begin
      hit  <= hit_next;
      turn <= turn_next;
    end
  end

  assign result.valid = valid_c;
  assign result.hit   = hit;
  assign result.turn  = turn;

endmodule

>>> src/sit_checker.sv
// Port checks for the segment intersection tests, bound to the top level.
// Depends on sit_pkg and segment_intersection_tests.
module sit_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           query_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic                           result_hit,
  input logic signed [sit_pkg::TURN_BITS-1:0] result_turn
);
  import sit_pkg::*;

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_hit) && $stable(result_turn))
    else $error("stalled result item changed");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> query_ready)
    else $error("query held off while result side drains");

  a_turn_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_turn == TURN_CCW || result_turn == TURN_CW ||
                      result_turn == TURN_BEHIND || result_turn == TURN_BEYOND ||
                      result_turn == TURN_BETWEEN))
    else $error("turn code out of range");

  a_hit_no_turn: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_hit |-> result_turn == TURN_BETWEEN)
    else $error("hit and turn both set");

endmodule

bind segment_intersection_tests sit_checker u_sit_checker (
  .clk          (clk),
  .rst          (rst),
  .query_ready  (query.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_hit   (result.hit),
  .result_turn  (result.turn)
);

>>> bench/intersection_checker.sv
`timescale 1ns / 100ps
// Answer checker for the segment intersection tests: watches the query and
// result channels, predicts each answer with exact integer geometry and
// compares. Depends on sit_pkg and the channel interfaces in sit_if.
module intersection_checker #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  sit_query_if  query,
  sit_result_if result,
  output int    failures,
  output int    outstanding
);
  import sit_pkg::*;

  localparam int WIDE_BITS = 2 * COORD_BITS + 8;

  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    logic  hit;
    turn_t turn;
  } answer_t;

  answer_t answer_q[$];

  function automatic int sign_of(wide_t v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  function automatic wide_t cross_prod(wide_t ax, wide_t ay, wide_t bx, wide_t by);
    return ax * by - ay * bx;
  endfunction

  function automatic turn_t turn_of(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                    wide_t cx, wide_t cy);
    wide_t ux, uy, vx, vy, s;
    ux = bx - ax;
    uy = by - ay;
    vx = cx - ax;
    vy = cy - ay;
    s = cross_prod(ux, uy, vx, vy);
    if (s > 0) return TURN_CCW;
    if (s < 0) return TURN_CW;
    if (ux * vx + uy * vy < 0) return TURN_BEHIND;
    if (ux * ux + uy * uy < vx * vx + vy * vy) return TURN_BEYOND;
    return TURN_BETWEEN;
  endfunction

  function automatic logic apart_or_on(turn_t a, turn_t b);
    return int'(a) * int'(b) <= 0;
  endfunction

  function automatic answer_t predict_answer(logic [KIND_BITS-1:0] kind,
                                             coord_t c0x, coord_t c0y,
                                             coord_t c1x, coord_t c1y,
                                             coord_t c2x, coord_t c2y,
                                             coord_t c3x, coord_t c3y);
    wide_t x0, y0, x1, y1, x2, y2, x3, y3, dx, dy;
    answer_t a;
    x0 = c0x;
    y0 = c0y;
    x1 = c1x;
    y1 = c1y;
    x2 = c2x;
    y2 = c2y;
    x3 = c3x;
    y3 = c3y;
    dx = x1 - x0;
    dy = y1 - y0;
    a.hit = 1'b0;
    a.turn = TURN_BETWEEN;
    case (kind)
      KIND_LINE_LINE: begin
        a.hit = cross_prod(dx, dy, x3 - x2, y3 - y2) != 0 ||
                cross_prod(dx, dy, x2 - x0, y2 - y0) == 0;
      end
      KIND_LINE_SEGMENT: begin
        a.hit = sign_of(cross_prod(dx, dy, x2 - x0, y2 - y0)) *
                sign_of(cross_prod(dx, dy, x3 - x0, y3 - y0)) <= 0;
      end
      KIND_LINE_POINT: begin
        a.hit = cross_prod(x1 - x2, y1 - y2, x0 - x2, y0 - y2) == 0;
      end
      KIND_SEG_SEG: begin
        a.hit = apart_or_on(turn_of(x0, y0, x1, y1, x2, y2),
                            turn_of(x0, y0, x1, y1, x3, y3)) &&
                apart_or_on(turn_of(x2, y2, x3, y3, x0, y0),
                            turn_of(x2, y2, x3, y3, x1, y1));
      end
      KIND_ORIENT: begin
        a.turn = turn_of(x0, y0, x1, y1, x2, y2);
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  initial begin
    failures = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      outstanding <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (answer_q.size() == 0) begin
          $error("result with no query outstanding: hit %0d, turn %0d",
                 result.hit, result.turn);
          failures++;
        end else begin
          want = answer_q.pop_front();
          if (result.hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, result.hit);
            failures++;
          end
          if (result.turn !== want.turn) begin
            $error("turn mismatch: expected %0d, actual %0d", want.turn, result.turn);
            failures++;
          end
        end
      end
      if (query.valid && query.ready) begin
        answer_q = {answer_q, predict_answer(query.kind, query.p0_x, query.p0_y,
                                             query.p1_x, query.p1_y, query.p2_x,
                                             query.p2_y, query.p3_x, query.p3_y)};
      end
      outstanding <= answer_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Top of the segment intersection tests bench: makes the query stream, paces
// both channels and gives the verdict. Depends on sit_pkg, sit_if, the block
// and intersection_checker.
module testbench;
  import sit_pkg::*;

  localparam int COORD_BITS   = COORD_BITS_DEFAULT;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 200;
  localparam int CMIN         = -(1 << (COORD_BITS - 1));
  localparam int CMAX         = (1 << (COORD_BITS - 1)) - 1;

  typedef enum int {PACE_RANDOM, PACE_FULL, PACE_SPARSE} pace_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  int    failures;
  int    outstanding;
  pace_t pace = PACE_RANDOM;
  bit    hold_req = 1'b0;
  int    pts[8];

  sit_query_if #(.COORD_BITS(COORD_BITS)) query_ch ();
  sit_result_if result_ch ();

  segment_intersection_tests #(.COORD_BITS(COORD_BITS)) u_top (
    .clk(clk),
    .rst(rst),
    .query(query_ch),
    .result(result_ch)
  );

  intersection_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk(clk),
    .rst(rst),
    .query(query_ch),
    .result(result_ch),
    .failures(failures),
    .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap();
    case (pace)
      PACE_FULL: return 0;
      PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic int full_coord();
    return $urandom_range(0, (1 << COORD_BITS) - 1) + CMIN;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return CMIN;
      1: return CMIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return CMAX - 1;
      default: return CMAX;
    endcase
  endfunction

  task automatic send_query(input logic [KIND_BITS-1:0] k, input int c0, input int c1,
                            input int c2, input int c3, input int c4, input int c5,
                            input int c6, input int c7, input bit settle);
    int gap;
    gap = draw_gap();
    if (settle || gap > 0) begin
      query_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (settle) begin
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
    end
    query_ch.valid <= 1'b1;
    query_ch.kind <= k;
    query_ch.p0_x <= c0[COORD_BITS-1:0];
    query_ch.p0_y <= c1[COORD_BITS-1:0];
    query_ch.p1_x <= c2[COORD_BITS-1:0];
    query_ch.p1_y <= c3[COORD_BITS-1:0];
    query_ch.p2_x <= c4[COORD_BITS-1:0];
    query_ch.p2_y <= c5[COORD_BITS-1:0];
    query_ch.p3_x <= c6[COORD_BITS-1:0];
    query_ch.p3_y <= c7[COORD_BITS-1:0];
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin : drain
    int stall;
    result_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int n, j, style, bx, by, dx, dy, step, sx, sy;
    logic [KIND_BITS-1:0] k;
    query_ch.valid = 1'b0;
    query_ch.kind = KIND_LINE_LINE;
    query_ch.p0_x = '0;
    query_ch.p0_y = '0;
    query_ch.p1_x = '0;
    query_ch.p1_y = '0;
    query_ch.p2_x = '0;
    query_ch.p2_y = '0;
    query_ch.p3_x = '0;
    query_ch.p3_y = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_query(KIND_ORIENT, 0, 0, 10, 0, 5, 5, 0, 0, 1'b0);
    send_query(KIND_ORIENT, 0, 0, 10, 0, 5, -5, 0, 0, 1'b0);
    send_query(KIND_ORIENT, 0, 0, 10, 0, -5, 0, 0, 0, 1'b0);
    send_query(KIND_ORIENT, 0, 0, 10, 0, 15, 0, 0, 0, 1'b0);
    send_query(KIND_ORIENT, 0, 0, 10, 0, 10, 0, 0, 0, 1'b0);
    send_query(KIND_ORIENT, 0, 0, 10, 0, 0, 0, 0, 0, 1'b0);
    send_query(KIND_ORIENT, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1'b0);
    send_query(KIND_ORIENT, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0);
    send_query(KIND_LINE_LINE, 0, 0, 10, 10, 0, 10, 10, 0, 1'b0);
    send_query(KIND_LINE_LINE, 0, 0, 10, 0, 0, 5, 10, 5, 1'b0);
    send_query(KIND_LINE_LINE, 0, 0, 10, 0, 20, 0, 30, 0, 1'b0);
    send_query(KIND_LINE_LINE, 3, 3, 3, 3, CMIN, 7, CMAX, -9, 1'b0);
    send_query(KIND_LINE_SEGMENT, 0, 0, 10, 0, 5, -5, 5, 5, 1'b0);
    send_query(KIND_LINE_SEGMENT, 0, 0, 10, 0, 5, 1, 7, 9, 1'b0);
    send_query(KIND_LINE_SEGMENT, 0, 0, 10, 0, 5, 0, 6, 9, 1'b0);
    send_query(KIND_LINE_POINT, 0, 0, 4, 4, -7, -7, 0, 0, 1'b0);
    send_query(KIND_LINE_POINT, 0, 0, 4, 4, -7, -6, 0, 0, 1'b0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 10, 0, 10, 10, 0, 1'b0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 0, 5, 0, 15, 0, 1'b0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 0, 11, 0, 20, 0, 1'b0);
    send_query(KIND_SEG_SEG, 0, 0, 10, 0, 10, 0, 10, 10, 1'b0);
    send_query(KIND_SEG_SEG, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1'b0);
    send_query(KIND_ORIENT + 3'd1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    send_query(KIND_ORIENT + 3'd2, CMIN, CMAX, 1, -1, 0, 0, CMAX, CMIN, 1'b0);
    send_query(KIND_ORIENT + 3'd3, CMAX, CMAX, CMIN, CMIN, 5, 5, 7, 7, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ((n >= 300 && n < 400) || (n >= 450 && n < 550)) begin
        pace = PACE_FULL;
      end else if (n >= 800 && n < 950) begin
        pace = PACE_SPARSE;
      end else begin
        pace = PACE_RANDOM;
      end
      if (n == 450) hold_req = 1'b1;

      if ($urandom_range(0, 19) < 18) begin
        k = KIND_BITS'($urandom_range(0, int'(KIND_ORIENT)));
      end else begin
        k = KIND_BITS'($urandom_range(int'(KIND_ORIENT) + 1, (1 << KIND_BITS) - 1));
      end

      style = $urandom_range(0, 9);
      case (style)
        0, 1, 2: begin
          foreach (pts[i]) pts[i] = full_coord();
        end
        3, 4: begin
          foreach (pts[i]) pts[i] = $urandom_range(0, 8) - 4;
        end
        5: begin
          foreach (pts[i]) pts[i] = extreme_coord();
        end
        default: begin
          // points on a line, whole steps of a small direction; styles 8, 9 move some off
          bx = $urandom_range(0, 4000) - 2000;
          by = $urandom_range(0, 4000) - 2000;
          dx = $urandom_range(0, 120) - 60;
          dy = $urandom_range(0, 120) - 60;
          for (j = 0; j < 4; j++) begin
            step = $urandom_range(0, 10) - 5;
            pts[2 * j] = bx + step * dx;
            pts[2 * j + 1] = by + step * dy;
          end
          if (style == 8) begin
            sx = $urandom_range(0, 20) - 10;
            sy = $urandom_range(0, 20) - 10;
            pts[4] += sx;
            pts[5] += sy;
            pts[6] += sx;
            pts[7] += sy;
          end
          if (style == 9) pts[$urandom_range(0, 7)] += $urandom_range(0, 2) - 1;
        end
      endcase

      send_query(k, pts[0], pts[1], pts[2], pts[3], pts[4], pts[5], pts[6], pts[7],
                 n == 700);
    end

    query_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
